// ----- hdl/dmbc_pkg.sv -----
package dmbc_pkg;

  // default sizes
  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int MAX_CELLS_DEF = 64;

  // fixed field widths
  localparam int BOARD_W = 64;
  localparam int VALUE_W = 16;
  localparam int HASH_W = 16;
  localparam int USED_W = 13;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_INDEX_W = 2;

  // symbol hashed for an empty cell
  localparam logic [7:0] EMPTY_SYMBOL = 8'd46;

  // reset values of the configuration registers
  localparam logic [3:0] WIDTH_RESET = 4'd7;
  localparam logic [3:0] HEIGHT_RESET = 4'd6;
  localparam logic [7:0] ONE_SYMBOL_RESET = 8'd88;
  localparam logic [7:0] TWO_SYMBOL_RESET = 8'd79;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BOARD_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOARD_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_SYMBOL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TWO_SYMBOL = 2'd3;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // cell codes
  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_ONE = 2'd1;
  localparam logic [1:0] CELL_TWO = 2'd2;
  localparam logic [1:0] CELL_ODD = 2'd3;

  // classified word handed from front to back
  typedef struct packed {
    logic [1:0]         op;
    logic [BOARD_W-1:0] key_high;
    logic [BOARD_W-1:0] key_low;
    logic [VALUE_W-1:0] value;
    logic [HASH_W-1:0]  index;
  } job_t;

  // one table slot as stored in memory
  typedef struct packed {
    logic               valid;
    logic [BOARD_W-1:0] key_high;
    logic [BOARD_W-1:0] key_low;
    logic [VALUE_W-1:0] value;
  } slot_t;

  // status from back to front
  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_EXEC} back_state_t;

endpackage

// ----- hdl/dmbc_if.sv -----
interface dmbc_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [dmbc_pkg::BOARD_W-1:0] board_cells_low;
  logic [dmbc_pkg::BOARD_W-1:0] board_cells_high;
  logic [dmbc_pkg::VALUE_W-1:0] store_value;
  modport source(output valid, op, board_cells_low, board_cells_high, store_value,
                 input ready);
  modport sink(input valid, op, board_cells_low, board_cells_high, store_value,
               output ready);
endinterface

interface dmbc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [dmbc_pkg::VALUE_W-1:0] found_value;
  logic [dmbc_pkg::USED_W-1:0]  entries_used;
  modport source(output valid, hit, found_value, entries_used, input ready);
  modport sink(input valid, hit, found_value, entries_used, output ready);
endinterface

// ----- hdl/dmbc_ram.sv -----
module dmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dmbc_front.sv -----
module dmbc_front #(
  parameter int TABLE_ENTRIES = dmbc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CELLS = dmbc_pkg::MAX_CELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dmbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dmbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  dmbc_req_if.sink                         req,
  input  dmbc_pkg::back_status_t           status,
  input  logic                             queue_full,
  output logic                             push,
  output dmbc_pkg::job_t                   push_job
);

  localparam int HW = dmbc_pkg::HASH_W;
  localparam longint unsigned RECIP =
    ((64'd1 << 32) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
  localparam logic [31:0] RECIP_M = 32'(RECIP);
  localparam logic [16:0] ENTRIES = 17'(TABLE_ENTRIES);
  localparam logic [6:0] CELL_CAP = 7'(MAX_CELLS);

  // configuration registers
  logic [3:0] board_width, board_height;
  logic [7:0] one_symbol, two_symbol;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_width <= dmbc_pkg::WIDTH_RESET;
      board_height <= dmbc_pkg::HEIGHT_RESET;
      one_symbol <= dmbc_pkg::ONE_SYMBOL_RESET;
      two_symbol <= dmbc_pkg::TWO_SYMBOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmbc_pkg::REG_BOARD_WIDTH: board_width <= cfg_data[3:0];
        dmbc_pkg::REG_BOARD_HEIGHT: board_height <= cfg_data[3:0];
        dmbc_pkg::REG_ONE_SYMBOL: one_symbol <= cfg_data;
        dmbc_pkg::REG_TWO_SYMBOL: two_symbol <= cfg_data;
      endcase
    end
  end

  function automatic logic [3:0] clamp_dim(input logic [3:0] d);
    if (d == 4'd0) return 4'd1;
    if (d > 4'd8) return 4'd8;
    return d;
  endfunction

  // cells in use
  logic [3:0] cw, ch;
  logic [7:0] n_full;
  logic [6:0] cells_in_use;

  always_comb begin
    cw = clamp_dim(board_width);
    ch = clamp_dim(board_height);
    n_full = cw * ch;
    cells_in_use = (n_full[6:0] > CELL_CAP) ? CELL_CAP : n_full[6:0];
  end

  // canonical key: odd code read as empty, unused cells zeroed
  logic [2*dmbc_pkg::BOARD_W-1:0] board_in, key_in;

  always_comb begin
    board_in = {req.board_cells_high, req.board_cells_low};
    key_in = '0;
    for (int i = 0; i < dmbc_pkg::BOARD_W; i++) begin
      if (7'(i) < cells_in_use && board_in[2*i +: 2] != dmbc_pkg::CELL_ODD) begin
        key_in[2*i +: 2] = board_in[2*i +: 2];
      end
    end
  end

  // state and working registers
  dmbc_pkg::front_state_t state, state_next;
  logic [1:0]                     op;
  logic [2*dmbc_pkg::BOARD_W-1:0] key;
  logic [dmbc_pkg::VALUE_W-1:0]   value;
  logic [6:0]                     cells;
  logic [HW-1:0]                  hash, hash_next;
  logic [2:0]                     step;
  logic                           mod_step;
  logic [HW-1:0]                  quot;
  logic [HW-1:0]                  rem, rem_next;
  logic [47:0]                    recip_prod;
  logic [32:0]                    quot_prod;
  logic                           hash_last;

  // eight cells of the shift-add hash per cycle
  always_comb begin
    logic [5:0] ci;
    logic [1:0] c;
    logic [7:0] sym;
    hash_next = hash;
    for (int j = 0; j < 8; j++) begin
      ci = {step, 3'(j)};
      c = key[2*ci +: 2];
      unique case (c)
        dmbc_pkg::CELL_ONE: sym = one_symbol;
        dmbc_pkg::CELL_TWO: sym = two_symbol;
        default: sym = dmbc_pkg::EMPTY_SYMBOL;
      endcase
      if (7'(ci) < cells) begin
        hash_next = (hash_next + HW'(sym)) << 1;
      end
    end
    hash_last = (7'({step, 3'b000}) + 7'd8) >= cells;
  end

  // slot index by reciprocal multiplication: quotient, then remainder
  always_comb begin
    recip_prod = {32'd0, hash} * {16'd0, RECIP_M};
    quot_prod = {17'd0, quot} * {16'd0, ENTRIES};
    rem_next = hash - quot_prod[HW-1:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmbc_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      dmbc_pkg::F_IDLE: begin
        op <= req.op;
        key <= key_in;
        value <= req.store_value;
        cells <= cells_in_use;
        hash <= '0;
        step <= '0;
      end
      dmbc_pkg::F_HASH: begin
        hash <= hash_next;
        step <= step + 3'd1;
        mod_step <= 1'b0;
      end
      dmbc_pkg::F_MOD: begin
        if (!mod_step) quot <= recip_prod[47:32];
        else rem <= rem_next;
        mod_step <= 1'b1;
      end
      dmbc_pkg::F_PUSH: begin
      end
    endcase
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    req.ready = 1'b0;
    push = 1'b0;
    unique case (state)
      dmbc_pkg::F_IDLE: begin
        req.ready = !status.clearing;
        if (req.valid && !status.clearing) state_next = dmbc_pkg::F_HASH;
      end
      dmbc_pkg::F_HASH: begin
        if (hash_last) state_next = dmbc_pkg::F_MOD;
      end
      dmbc_pkg::F_MOD: begin
        if (mod_step) state_next = dmbc_pkg::F_PUSH;
      end
      dmbc_pkg::F_PUSH: begin
        push = !queue_full;
        if (!queue_full) state_next = dmbc_pkg::F_IDLE;
      end
    endcase
  end

  assign push_job.op = op;
  assign push_job.key_high = key[2*dmbc_pkg::BOARD_W-1:dmbc_pkg::BOARD_W];
  assign push_job.key_low = key[dmbc_pkg::BOARD_W-1:0];
  assign push_job.value = value;
  assign push_job.index = rem;

endmodule

// ----- hdl/dmbc_queue.sv -----
module dmbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dmbc_pkg::job_t push_job,
  input  logic           pop,
  output dmbc_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  dmbc_pkg::job_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  // two-entry fifo
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_job;
  end

  assign head = entry[rd_ptr];
  assign full = count == 2'd2;
  assign empty = count == 2'd0;

endmodule

// ----- hdl/dmbc_back.sv -----
module dmbc_back #(
  parameter int TABLE_ENTRIES = dmbc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dmbc_pkg::job_t         head,
  input  logic                   empty,
  output logic                   pop,
  output dmbc_pkg::back_status_t status,
  dmbc_rsp_if.source             rsp
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = $bits(dmbc_pkg::slot_t);
  localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_ENTRIES - 1);

  dmbc_pkg::back_state_t state, state_next;
  dmbc_pkg::job_t        job;
  dmbc_pkg::slot_t       rd_slot, wr_slot;
  logic [SW-1:0]         rdata;
  logic [IW-1:0]         clr_addr, raddr, waddr;
  logic [CW-1:0]         count, count_next;
  logic                  we, out_free, match, finish;
  logic                  hit_next;
  logic [dmbc_pkg::VALUE_W-1:0] value_next;

  // slot table
  dmbc_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wr_slot),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_slot = rdata;
  assign out_free = !rsp.valid || rsp.ready;
  assign raddr = pop ? head.index[IW-1:0] : job.index[IW-1:0];
  assign match = rd_slot.valid && rd_slot.key_low == job.key_low &&
                 rd_slot.key_high == job.key_high;
  assign status.clearing = state == dmbc_pkg::B_CLEAR;

  // clearing pass, then read-modify-write of one slot per job
  always_comb begin
    state_next = state;
    pop = 1'b0;
    we = 1'b0;
    finish = 1'b0;
    waddr = job.index[IW-1:0];
    wr_slot = '0;
    count_next = count;
    hit_next = 1'b0;
    value_next = '0;
    unique case (state)
      dmbc_pkg::B_CLEAR: begin
        we = 1'b1;
        waddr = clr_addr;
        if (clr_addr == LAST_ADDR) state_next = dmbc_pkg::B_IDLE;
      end
      dmbc_pkg::B_IDLE: begin
        pop = !empty;
        if (!empty) state_next = dmbc_pkg::B_EXEC;
      end
      dmbc_pkg::B_EXEC: begin
        if (out_free) begin
          finish = 1'b1;
          state_next = dmbc_pkg::B_IDLE;
          priority case (job.op)
            dmbc_pkg::OP_LOOKUP: begin
              hit_next = match;
              value_next = match ? rd_slot.value : '0;
            end
            dmbc_pkg::OP_STORE: begin
              we = 1'b1;
              wr_slot.valid = 1'b1;
              wr_slot.key_low = job.key_low;
              wr_slot.key_high = job.key_high;
              wr_slot.value = job.value;
              if (!rd_slot.valid) count_next = count + CW'(1);
            end
            dmbc_pkg::OP_DELETE: begin
              we = 1'b1;
              if (rd_slot.valid && count != '0) count_next = count - CW'(1);
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmbc_pkg::B_CLEAR;
      clr_addr <= '0;
      count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dmbc_pkg::B_CLEAR) clr_addr <= clr_addr + IW'(1);
      count <= count_next;
      if (finish) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // job and result word
  always_ff @(posedge clk) begin
    if (pop) job <= head;
    if (finish) begin
      rsp.hit <= hit_next;
      rsp.found_value <= value_next;
      rsp.entries_used <= dmbc_pkg::USED_W'(count_next);
    end
  end

endmodule

// ----- hdl/direct_mapped_board_cache.sv -----
// path from accepted request word to result word: hash steps, index quotient and
//   remainder, queue push, slot read, then write-back
// intake: a new request word is taken only after the previous one is in the queue
// reset: synchronous; afterwards a clearing pass zeroes every slot of the memory,
//   req.ready stays low during it, configuration is taken
module direct_mapped_board_cache #(
  parameter int TABLE_ENTRIES = dmbc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CELLS = dmbc_pkg::MAX_CELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dmbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dmbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  dmbc_req_if.sink                         req,
  dmbc_rsp_if.source                       rsp
);

  dmbc_pkg::job_t         push_job, head;
  dmbc_pkg::back_status_t status;
  logic                   push, pop, full, empty;

  // classify: canonical key and slot index
  dmbc_front #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CELLS(MAX_CELLS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .status    (status),
    .queue_full(full),
    .push      (push),
    .push_job  (push_job)
  );

  // decoupling queue
  dmbc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  // table access
  dmbc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .status(status),
    .rsp   (rsp)
  );

endmodule

// ----- hdl/dmbc_checker.sv -----
module dmbc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_hit,
  input logic [dmbc_pkg::VALUE_W-1:0] rsp_found_value,
  input logic [dmbc_pkg::USED_W-1:0]  rsp_entries_used
);

  // no result word and no request ready right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid && !req_ready)
    else $error("result or ready right after reset");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
    $stable(rsp_found_value) && $stable(rsp_entries_used))
    else $error("stalled result word changed");

  // a miss carries a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> rsp_found_value == '0)
    else $error("miss with nonzero value");

  // used count moves by at most one between words
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready ##1 rsp_valid |->
    rsp_entries_used == $past(rsp_entries_used) ||
    rsp_entries_used == $past(rsp_entries_used) + 1'b1 ||
    rsp_entries_used == $past(rsp_entries_used) - 1'b1)
    else $error("used count jumped");

endmodule

bind direct_mapped_board_cache dmbc_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_hit         (rsp.hit),
  .rsp_found_value (rsp.found_value),
  .rsp_entries_used(rsp.entries_used)
);

// ----- verif/dmbc_checker.sv -----
module dmbc_scoreboard (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dmbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dmbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  dmbc_req_if                              req,
  dmbc_rsp_if                              rsp,
  output int                               mismatches,
  output int                               outstanding
);

  localparam int ENTRIES = dmbc_pkg::TABLE_ENTRIES_DEF;
  localparam int CELLS_CAP = dmbc_pkg::MAX_CELLS_DEF;

  typedef struct {
    logic                         hit;
    logic [dmbc_pkg::VALUE_W-1:0] value;
    logic [dmbc_pkg::USED_W-1:0]  used;
  } reply_t;

  // predicted configuration
  logic [3:0] cols, rows;
  logic [7:0] sym_one, sym_two;

  // predicted table
  logic                         tbl_valid [ENTRIES];
  logic [dmbc_pkg::BOARD_W-1:0] tbl_key_lo [ENTRIES];
  logic [dmbc_pkg::BOARD_W-1:0] tbl_key_hi [ENTRIES];
  logic [dmbc_pkg::VALUE_W-1:0] tbl_value [ENTRIES];
  logic [dmbc_pkg::USED_W-1:0]  used_count;

  reply_t expected_replies[$];

  assign outstanding = expected_replies.size();

  function automatic int clamp_size(logic [3:0] d);
    if (d < 1) return 1;
    if (d > 8) return 8;
    return d;
  endfunction

  // hash over cells in use, also builds the canonical key
  function automatic int hash_board(input logic [dmbc_pkg::BOARD_W-1:0] lo,
                                    input logic [dmbc_pkg::BOARD_W-1:0] hi,
                                    output logic [dmbc_pkg::BOARD_W-1:0] klo,
                                    output logic [dmbc_pkg::BOARD_W-1:0] khi);
    int n;
    logic [dmbc_pkg::HASH_W-1:0] h;
    logic [1:0] c;
    logic [7:0] s;
    n = clamp_size(cols) * clamp_size(rows);
    if (n > CELLS_CAP) n = CELLS_CAP;
    h = '0;
    klo = '0;
    khi = '0;
    for (int i = 0; i < n; i++) begin
      c = (i < 32) ? lo[2*i +: 2] : hi[2*(i-32) +: 2];
      if (c == dmbc_pkg::CELL_ODD) c = dmbc_pkg::CELL_EMPTY;
      if (c == dmbc_pkg::CELL_ONE) s = sym_one;
      else if (c == dmbc_pkg::CELL_TWO) s = sym_two;
      else s = dmbc_pkg::EMPTY_SYMBOL;
      h = (h + dmbc_pkg::HASH_W'(s)) << 1;
      if (i < 32) klo[2*i +: 2] = c;
      else khi[2*(i-32) +: 2] = c;
    end
    return int'(h) % ENTRIES;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    reply_t r, want;
    int idx;
    logic [dmbc_pkg::BOARD_W-1:0] klo, khi;
    if (rst) begin
      cols <= dmbc_pkg::WIDTH_RESET;
      rows <= dmbc_pkg::HEIGHT_RESET;
      sym_one <= dmbc_pkg::ONE_SYMBOL_RESET;
      sym_two <= dmbc_pkg::TWO_SYMBOL_RESET;
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      used_count = '0;
      expected_replies.delete();
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          dmbc_pkg::REG_BOARD_WIDTH: cols <= cfg_data[3:0];
          dmbc_pkg::REG_BOARD_HEIGHT: rows <= cfg_data[3:0];
          dmbc_pkg::REG_ONE_SYMBOL: sym_one <= cfg_data;
          dmbc_pkg::REG_TWO_SYMBOL: sym_two <= cfg_data;
          default: ;
        endcase
      end
      // compare result word against oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("pending predictions", 0, 1);
        end else begin
          want = expected_replies.pop_front();
          if (rsp.hit !== want.hit) report_mismatch("hit", rsp.hit, want.hit);
          if (rsp.found_value !== want.value)
            report_mismatch("found_value", rsp.found_value, want.value);
          if (rsp.entries_used !== want.used)
            report_mismatch("entries_used", rsp.entries_used, want.used);
        end
      end
      // predict result of accepted request word
      if (req.valid && req.ready) begin
        idx = hash_board(req.board_cells_low, req.board_cells_high, klo, khi);
        r.hit = 1'b0;
        r.value = '0;
        case (req.op)
          dmbc_pkg::OP_LOOKUP: begin
            if (tbl_valid[idx] && tbl_key_lo[idx] == klo && tbl_key_hi[idx] == khi) begin
              r.hit = 1'b1;
              r.value = tbl_value[idx];
            end
          end
          dmbc_pkg::OP_STORE: begin
            if (!tbl_valid[idx]) used_count++;
            tbl_valid[idx] = 1'b1;
            tbl_key_lo[idx] = klo;
            tbl_key_hi[idx] = khi;
            tbl_value[idx] = req.store_value;
          end
          dmbc_pkg::OP_DELETE: begin
            if (tbl_valid[idx] && used_count > 0) used_count--;
            tbl_valid[idx] = 1'b0;
          end
          default: ;
        endcase
        r.used = used_count;
        expected_replies.push_back(r);
      end
    end
  end
endmodule

// ----- verif/testbench.sv -----
module testbench;

  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 170;

  logic clk, rst;
  logic cfg_we;
  logic [dmbc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dmbc_pkg::CFG_DATA_W-1:0] cfg_data;
  int mismatches, outstanding;
  int send_idle_pct, recv_idle_pct;
  int words_sent;
  bit hold_off_req;
  int quiet_cycles;

  logic [dmbc_pkg::BOARD_W-1:0] pool_lo [16];
  logic [dmbc_pkg::BOARD_W-1:0] pool_hi [16];

  dmbc_req_if req ();
  dmbc_rsp_if rsp ();

  direct_mapped_board_cache u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .rsp(rsp)
  );

  dmbc_scoreboard u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .rsp(rsp),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int hold;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp.ready <= 1'b0;
        hold = 400;
        while (hold > 0) begin
          @(posedge clk);
          hold--;
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // offer one request word, with random idle before it
  task automatic send_word(logic [1:0] op, logic [dmbc_pkg::BOARD_W-1:0] lo,
                           logic [dmbc_pkg::BOARD_W-1:0] hi,
                           logic [dmbc_pkg::VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.board_cells_low <= lo;
    req.board_cells_high <= hi;
    req.store_value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    words_sent++;
    send_idle_pct = (words_sent < 350) ? 37 : (words_sent < 700) ? 78 : 0;
    recv_idle_pct = (words_sent < 350) ? 78 : (words_sent < 700) ? 37 : 0;
  endtask

  // drain, then write all four registers
  task automatic set_config(logic [3:0] w, logic [3:0] h, logic [7:0] s1, logic [7:0] s2);
    logic [dmbc_pkg::CFG_DATA_W-1:0] vals [4];
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    vals[0] = {4'd0, w};
    vals[1] = {4'd0, h};
    vals[2] = s1;
    vals[3] = s2;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= dmbc_pkg::CFG_INDEX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [dmbc_pkg::BOARD_W-1:0] rand_board();
    return {$urandom, $urandom};
  endfunction

  // random words: mostly boards from a small pool so lookups hit
  task automatic random_words(int count);
    int p;
    logic [1:0] op;
    logic [dmbc_pkg::BOARD_W-1:0] lo, hi;
    for (int i = 0; i < 16; i++) begin
      pool_lo[i] = rand_board();
      pool_hi[i] = rand_board();
    end
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(15);
      if ($urandom_range(99) < 75) begin
        lo = pool_lo[p];
        hi = pool_hi[p];
      end else begin
        lo = rand_board();
        hi = rand_board();
        if ($urandom_range(1)) begin
          pool_lo[p] = lo;
          pool_hi[p] = hi;
        end
      end
      case ($urandom_range(19))
        0: op = dmbc_pkg::OP_UNUSED;
        1, 2, 3: op = dmbc_pkg::OP_DELETE;
        4, 5, 6, 7, 8, 9: op = dmbc_pkg::OP_STORE;
        default: op = dmbc_pkg::OP_LOOKUP;
      endcase
      send_word(op, lo, hi, dmbc_pkg::VALUE_W'($urandom));
    end
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.op = dmbc_pkg::OP_LOOKUP;
    req.board_cells_low = '0;
    req.board_cells_high = '0;
    req.store_value = '0;
    hold_off_req = 1'b0;
    words_sent = 0;
    send_idle_pct = 37;
    recv_idle_pct = 78;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset sizes
    send_word(dmbc_pkg::OP_LOOKUP, '0, '0, '0);
    send_word(dmbc_pkg::OP_STORE, '0, '0, 16'hFFFF);
    send_word(dmbc_pkg::OP_LOOKUP, '0, '0, '0);
    // odd cell code reads as empty
    send_word(dmbc_pkg::OP_LOOKUP, '1, '1, '0);
    send_word(dmbc_pkg::OP_STORE, {32{2'b01}}, {32{2'b01}}, 16'h0000);
    send_word(dmbc_pkg::OP_LOOKUP, {32{2'b01}}, '0, '0);
    send_word(dmbc_pkg::OP_STORE, {32{2'b10}}, {32{2'b10}}, 16'h1234);
    send_word(dmbc_pkg::OP_LOOKUP, {32{2'b10}}, {32{2'b10}}, '0);
    send_word(dmbc_pkg::OP_DELETE, {32{2'b10}}, '0, '0);
    send_word(dmbc_pkg::OP_DELETE, {32{2'b10}}, '0, '0);
    send_word(dmbc_pkg::OP_LOOKUP, {32{2'b10}}, '0, '0);
    send_word(dmbc_pkg::OP_UNUSED, {32{2'b01}}, '0, 16'hBEEF);
    // cells beyond those in use are ignored
    send_word(dmbc_pkg::OP_STORE, 64'h0000_0000_0000_0124, '1, 16'hA5A5);
    send_word(dmbc_pkg::OP_LOOKUP, 64'hFFFF_FC00_0000_0124, '0, '0);
    send_word(dmbc_pkg::OP_DELETE, '0, '0, '0);
    send_word(dmbc_pkg::OP_LOOKUP, '0, '0, '0);
    hold_off_req = 1'b1;
    random_words(RANDOM_PER_PHASE);

    set_config(4'd8, 4'd8, 8'd255, 8'd1);
    send_word(dmbc_pkg::OP_STORE, '1, {32{2'b01}}, 16'h7777);
    send_word(dmbc_pkg::OP_LOOKUP, '0, {32{2'b01}}, '0);
    send_word(dmbc_pkg::OP_LOOKUP, '0, {32{2'b10}}, '0);
    random_words(RANDOM_PER_PHASE);

    set_config(4'd1, 4'd1, 8'd1, 8'd255);
    random_words(RANDOM_PER_PHASE);

    set_config(4'd0, 4'd0, 8'd46, 8'd46);
    random_words(RANDOM_PER_PHASE);

    set_config(4'd15, 4'd15, 8'd128, 8'd127);
    random_words(RANDOM_PER_PHASE);

    set_config(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
               8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    random_words(RANDOM_PER_PHASE);

    // drain and settle
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/dmbc_pkg.sv
hdl/dmbc_if.sv
hdl/dmbc_ram.sv
hdl/dmbc_front.sv
hdl/dmbc_queue.sv
hdl/dmbc_back.sv
hdl/direct_mapped_board_cache.sv
hdl/dmbc_checker.sv
verif/dmbc_checker.sv
verif/testbench.sv
